### sv/drive_direction_torque_controller_core_defines.svh
// ---------------------------------------------------------------------------
// Drive direction torque controller: assertion macros
// Shared property shorthands; clk and rst_n are taken from the using scope.
// ---------------------------------------------------------------------------
`ifndef DRIVE_DIRECTION_TORQUE_CONTROLLER_CORE_DEFINES_SVH
`define DRIVE_DIRECTION_TORQUE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define DDTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddtc: same-cycle check failed");

// next-cycle implication
`define DDTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddtc: next-cycle check failed");

`endif

### sv/ddtc_pkg.sv
// ---------------------------------------------------------------------------
// ddtc_pkg
// Types, constants and helpers of the drive direction torque controller.
// ---------------------------------------------------------------------------
package ddtc_pkg;

  // throttle curve
  localparam int unsigned PCT_FULL = 100;
  localparam int unsigned KNEE_PCT = 30;

  // constant dividers, done as exact reciprocal multiplies (ceil(2^s/d), s = N + log2 d)
  localparam int unsigned NUM_W    = 22;  // widest dividend
  localparam int unsigned RCP_W    = 23;
  localparam int unsigned KNEE_DEN = 75;  // t*iq*80/3000 = 2*t*iq/75
  localparam int unsigned TOP_DEN  = 350; // (t-30)*iq*20/7000
  localparam int unsigned BASE_DEN = 5;   // iq*80/100 = 4*iq/5
  localparam int unsigned KNEE_SH  = 29;
  localparam int unsigned TOP_SH   = 31;
  localparam int unsigned BASE_SH  = 25;
  localparam int unsigned PCT_SH   = 29;
  localparam logic [RCP_W-1:0] KNEE_RCP =
    RCP_W'(((64'd1 << KNEE_SH) + 64'(KNEE_DEN) - 64'd1) / 64'(KNEE_DEN));
  localparam logic [RCP_W-1:0] TOP_RCP =
    RCP_W'(((64'd1 << TOP_SH) + 64'(TOP_DEN) - 64'd1) / 64'(TOP_DEN));
  localparam logic [RCP_W-1:0] BASE_RCP =
    RCP_W'(((64'd1 << BASE_SH) + 64'(BASE_DEN) - 64'd1) / 64'(BASE_DEN));
  localparam logic [RCP_W-1:0] PCT_RCP =
    RCP_W'(((64'd1 << PCT_SH) + 64'(PCT_FULL) - 64'd1) / 64'(PCT_FULL));

  // reported state codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DRIVE  = 2'd1;
  localparam logic [1:0] ST_SMOOTH = 2'd2;

  // drive mode codes
  localparam logic [1:0] MODE_ECO    = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_SPORT  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;  // unused code, behaves as sport

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_DRIVE  = 3'b010,
    PH_SMOOTH = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    CFG_MAX_TORQUE   = 3'd0,
    CFG_ECO_VLIM     = 3'd1,
    CFG_NORMAL_VLIM  = 3'd2,
    CFG_SPORT_VLIM   = 3'd3,
    CFG_REVERSE_VLIM = 3'd4,
    CFG_START_LEVEL  = 3'd5,
    CFG_RAMP_UP      = 3'd6,
    CFG_RAMP_DOWN    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [14:0] max_torque_current;
    logic [14:0] eco_voltage_limit;
    logic [14:0] normal_voltage_limit;
    logic [14:0] sport_voltage_limit;
    logic [14:0] reverse_voltage_limit;
    logic [6:0]  throttle_start_level;
    logic [9:0]  ramp_up_step;
    logic [9:0]  ramp_down_step;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         throttle_pct;
    logic               brake;
    logic               reverse_switch;
    logic [1:0]         mode_sel;
    logic signed [15:0] shaft_speed;
    logic               motor_idle;
  } in_t;

  typedef struct packed {
    logic [1:0]         ctrl_state;
    logic               direction;
    logic               torque_valid;
    logic signed [15:0] torque_cmd;
    logic               vlimit_valid;
    logic [14:0]        vlimit_value;
    logic               start_motor;
    logic               stop_motor;
  } out_t;

  // item after the arithmetic stages, ready for the state update
  typedef struct packed {
    logic [7:0]  thr;
    logic        brake;
    logic        req;
    logic [1:0]  mode;
    logic        stopped;
    logic        motor_idle;
    logic        knee;       // clamped throttle below the knee
    logic [14:0] mag_part;   // slope term of the torque curve
    logic [14:0] knee_base;  // torque at the knee
    logic [14:0] vlim_fwd;   // forward target limit
    logic [14:0] vlim_rev;   // reverse target limit
  } work_t;

  typedef struct packed {
    phase_t phase;
    logic   dir;
    logic   pend;
  } ctrl_stat_t;

  // forward limit of a mode; code three counts as sport
  function automatic logic [14:0] mode_limit(cfg_t c, logic [1:0] mode);
    logic [14:0] lim;
    if (mode == MODE_ECO) begin
      lim = c.eco_voltage_limit;
    end else if (mode == MODE_NORMAL) begin
      lim = c.normal_voltage_limit;
    end else begin
      lim = c.sport_voltage_limit;
    end
    return lim;
  endfunction

endpackage

### sv/drive_direction_torque_controller_core.sv
// ---------------------------------------------------------------------------
// drive_direction_torque_controller_core
// Per-tick drive controller: direction, torque command and voltage limit.
// ---------------------------------------------------------------------------
// Channel   Ports                         Moves
// input     in_valid/in_ready/in_data     one control tick item
// result    out_valid/out_ready/out_data  one result item per tick
// config    cfg_we/cfg_addr/cfg_wdata     register write, no wait
//
// One item per cycle sustained while the result channel is not stalled; a
// result passes the input reg, product stage, divide stage and result reg
// before it shows on out_valid.
// The rate is set by the state update in the last stage.
// Synchronous active-low reset clears all valids, the machine to idle,
// forward direction and a zero ramped limit; registers to their defaults.
// A stalled result only holds the stages that are full: bubbles still fill.
// ---------------------------------------------------------------------------
`include "drive_direction_torque_controller_core_defines.svh"

module drive_direction_torque_controller_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ddtc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ddtc_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_addr,
  input  logic [14:0]    cfg_wdata
);
  import ddtc_pkg::*;

  // configuration registers
  cfg_t       cfg_r;

  // input register
  logic       v0_r, v0_nxt;
  in_t        d0_r;
  logic       s0_ready;

  // arithmetic to control
  logic       s2_valid, s2_ready, s2_take;
  work_t      s2_data;
  ctrl_stat_t stat;

  // write only while idle, so the stages never see a change mid-item; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_torque_current    <= 15'd10000;
      cfg_r.eco_voltage_limit     <= 15'd16700;
      cfg_r.normal_voltage_limit  <= 15'd22200;
      cfg_r.sport_voltage_limit   <= 15'd24000;
      cfg_r.reverse_voltage_limit <= 15'd12000;
      cfg_r.throttle_start_level  <= 7'd10;
      cfg_r.ramp_up_step          <= 10'd10;
      cfg_r.ramp_down_step        <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MAX_TORQUE:   cfg_r.max_torque_current    <= cfg_wdata;
        CFG_ECO_VLIM:     cfg_r.eco_voltage_limit     <= cfg_wdata;
        CFG_NORMAL_VLIM:  cfg_r.normal_voltage_limit  <= cfg_wdata;
        CFG_SPORT_VLIM:   cfg_r.sport_voltage_limit   <= cfg_wdata;
        CFG_REVERSE_VLIM: cfg_r.reverse_voltage_limit <= cfg_wdata;
        CFG_START_LEVEL:  cfg_r.throttle_start_level  <= cfg_wdata[6:0];
        CFG_RAMP_UP:      cfg_r.ramp_up_step          <= cfg_wdata[9:0];
        CFG_RAMP_DOWN:    cfg_r.ramp_down_step        <= cfg_wdata[9:0];
        default:          cfg_r.ramp_down_step        <= cfg_r.ramp_down_step;
      endcase
    end
  end

  // input register: takes a new item whenever it is empty or can pass its own on
  assign in_ready = !v0_r || s0_ready;
  assign v0_nxt   = in_ready ? in_valid : v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d0_r <= in_data;
    end
  end

  // products and constant divides; none depends on the machine state
  ddtc_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s0_valid (v0_r),
    .s0_data  (d0_r),
    .s0_ready (s0_ready),
    .s2_valid (s2_valid),
    .s2_data  (s2_data),
    .s2_ready (s2_ready)
  );

  // state machine, ramp and result register
  ddtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s2_valid  (s2_valid),
    .s2_data   (s2_data),
    .s2_ready  (s2_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ready),
    .stat      (stat)
  );

  assign s2_take = s2_valid && s2_ready;

  // a pending reversal only lives inside smooth stop
  `DDTC_ASSERT_IMP(a_pend_in_smooth, stat.pend, stat.phase == PH_SMOOTH)
  // direction moves only on an item taken at standstill
  `DDTC_ASSERT_NXT(a_dir_at_standstill, !(s2_take && s2_data.stopped), $stable(stat.dir))
  // start pulse only with a drive torque command
  `DDTC_ASSERT_IMP(a_start_in_drive, out_valid && out_data.start_motor,
    out_data.ctrl_state == ST_DRIVE && out_data.torque_valid && !out_data.stop_motor)
  // stop pulse only at standstill, back in idle, with the zero torque command
  `DDTC_ASSERT_IMP(a_stop_to_idle, out_valid && out_data.stop_motor,
    out_data.ctrl_state == ST_IDLE && out_data.vlimit_valid && out_data.torque_valid)

endmodule

### sv/ddtc_arith.sv
// ---------------------------------------------------------------------------
// ddtc_arith
// Two arithmetic stages: products, then constant divides by reciprocal.
// ---------------------------------------------------------------------------
module ddtc_arith (
  input  logic           clk,
  input  logic           rst_n,
  input  ddtc_pkg::cfg_t cfg,
  input  logic           s0_valid,
  input  ddtc_pkg::in_t  s0_data,
  output logic           s0_ready,
  output logic           s2_valid,
  output ddtc_pkg::work_t s2_data,
  input  logic           s2_ready
);
  import ddtc_pkg::*;

  typedef struct packed {
    logic [7:0]       thr;
    logic             brake;
    logic             req;
    logic [1:0]       mode;
    logic             stopped;
    logic             motor_idle;
    logic             knee;
    logic [NUM_W-1:0] num_mag;
    logic [14:0]      iq;
    logic [NUM_W-1:0] num_fwd;
    logic [NUM_W-1:0] num_rev;
  } prod_t;

  logic        v1_r, v1_nxt, v2_r, v2_nxt;
  logic        rdy1, rdy2;
  prod_t       st1_r, st1_nxt;
  work_t       st2_r, st2_nxt;

  logic [6:0]  t;
  logic [6:0]  t_top;

  logic [NUM_W+RCP_W-1:0] p_knee, p_top, p_fwd, p_rev;
  logic [17+RCP_W-1:0]    p_base;

  assign rdy2     = !v2_r || s2_ready;
  assign rdy1     = !v1_r || rdy2;
  assign s0_ready = rdy1;
  assign s2_valid = v2_r;
  assign s2_data  = st2_r;

  // stage 1: clamp and products
  always_comb begin
    t     = (s0_data.throttle_pct > 8'(PCT_FULL)) ? 7'(PCT_FULL) : s0_data.throttle_pct[6:0];
    t_top = t - 7'(KNEE_PCT);
    st1_nxt.thr        = s0_data.throttle_pct;
    st1_nxt.brake      = s0_data.brake;
    st1_nxt.req        = s0_data.reverse_switch;
    st1_nxt.mode       = s0_data.mode_sel;
    st1_nxt.stopped    = (s0_data.shaft_speed == 16'sd0);
    st1_nxt.motor_idle = s0_data.motor_idle;
    st1_nxt.knee       = (t < 7'(KNEE_PCT));
    st1_nxt.iq         = cfg.max_torque_current;
    if (st1_nxt.knee) begin
      st1_nxt.num_mag = NUM_W'({t, 1'b0}) * NUM_W'(cfg.max_torque_current);
    end else begin
      st1_nxt.num_mag = NUM_W'(t_top) * NUM_W'(cfg.max_torque_current);
    end
    st1_nxt.num_fwd = NUM_W'(mode_limit(cfg, s0_data.mode_sel)) * NUM_W'(t);
    st1_nxt.num_rev = NUM_W'(cfg.reverse_voltage_limit) * NUM_W'(t);
  end

  // stage 2: exact quotients
  always_comb begin
    p_knee = (NUM_W+RCP_W)'(st1_r.num_mag) * (NUM_W+RCP_W)'(KNEE_RCP);
    p_top  = (NUM_W+RCP_W)'(st1_r.num_mag) * (NUM_W+RCP_W)'(TOP_RCP);
    p_base = (17+RCP_W)'({st1_r.iq, 2'b00}) * (17+RCP_W)'(BASE_RCP);
    p_fwd  = (NUM_W+RCP_W)'(st1_r.num_fwd) * (NUM_W+RCP_W)'(PCT_RCP);
    p_rev  = (NUM_W+RCP_W)'(st1_r.num_rev) * (NUM_W+RCP_W)'(PCT_RCP);
    st2_nxt.thr        = st1_r.thr;
    st2_nxt.brake      = st1_r.brake;
    st2_nxt.req        = st1_r.req;
    st2_nxt.mode       = st1_r.mode;
    st2_nxt.stopped    = st1_r.stopped;
    st2_nxt.motor_idle = st1_r.motor_idle;
    st2_nxt.knee       = st1_r.knee;
    st2_nxt.mag_part   = st1_r.knee ? 15'(p_knee >> KNEE_SH) : 15'(p_top >> TOP_SH);
    st2_nxt.knee_base  = 15'(p_base >> BASE_SH);
    st2_nxt.vlim_fwd   = 15'(p_fwd >> PCT_SH);
    st2_nxt.vlim_rev   = 15'(p_rev >> PCT_SH);
  end

  assign v1_nxt = rdy1 ? s0_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s0_valid) begin
      st1_r <= st1_nxt;
    end
    if (rdy2 && v1_r) begin
      st2_r <= st2_nxt;
    end
  end

endmodule

### sv/ddtc_ctrl.sv
// ---------------------------------------------------------------------------
// ddtc_ctrl
// Idle / drive / smooth-stop machine, voltage limit ramp, result register.
// ---------------------------------------------------------------------------
module ddtc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddtc_pkg::cfg_t       cfg,
  input  logic                 s2_valid,
  input  ddtc_pkg::work_t      s2_data,
  output logic                 s2_ready,
  output logic                 out_valid,
  output ddtc_pkg::out_t       out_data,
  input  logic                 out_ready,
  output ddtc_pkg::ctrl_stat_t stat
);
  import ddtc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        dir_r, dir_nxt;
  logic        pend_r, pend_nxt;
  logic [14:0] ramp_r, ramp_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, res;

  logic        take;
  logic        above, below, mism;
  logic [14:0] target, diff, step;
  logic [14:0] mag;

  assign s2_ready  = !out_valid_r || out_ready;
  assign take      = s2_valid && s2_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign stat      = '{phase: phase_r, dir: dir_r, pend: pend_r};

  always_comb begin
    above = s2_data.thr > {1'b0, cfg.throttle_start_level};
    below = s2_data.thr < {1'b0, cfg.throttle_start_level};
    mism  = dir_r != s2_data.req;

    // ramp toward the target of the current direction
    target = dir_r ? s2_data.vlim_rev : s2_data.vlim_fwd;
    if (ramp_r < target) begin
      diff = target - ramp_r;
      step = (15'(cfg.ramp_up_step) < diff) ? 15'(cfg.ramp_up_step) : diff;
    end else begin
      diff = ramp_r - target;
      step = (15'(cfg.ramp_down_step) < diff) ? 15'(cfg.ramp_down_step) : diff;
    end
    mag = s2_data.knee ? s2_data.mag_part : 15'(s2_data.knee_base + s2_data.mag_part);

    phase_nxt = phase_r;
    dir_nxt   = dir_r;
    pend_nxt  = pend_r;
    ramp_nxt  = ramp_r;
    res       = '0;

    // standstill writes the mode's forward limit first
    if (s2_data.stopped) begin
      res.vlimit_valid = 1'b1;
      res.vlimit_value = mode_limit(cfg, s2_data.mode);
    end

    unique case (phase_r)
      PH_IDLE: begin
        if (mism && s2_data.stopped) begin
          dir_nxt = s2_data.req;
        end
        if (above && !s2_data.brake) begin
          if ((mism && !s2_data.stopped)) begin
            pend_nxt  = 1'b1;
            phase_nxt = PH_SMOOTH;
          end else begin
            phase_nxt = PH_DRIVE;
          end
        end
      end
      PH_DRIVE: begin
        if (s2_data.brake || below || mism) begin
          if (mism) begin
            pend_nxt = 1'b1;
          end
          phase_nxt = PH_SMOOTH;
        end else begin
          ramp_nxt         = (ramp_r < target) ? ramp_r + step : ramp_r - step;
          res.vlimit_valid = 1'b1;
          res.vlimit_value = ramp_nxt;
          res.torque_valid = 1'b1;
          res.torque_cmd   = dir_r ? 16'sd0 - signed'({1'b0, mag}) : signed'({1'b0, mag});
          res.start_motor  = s2_data.motor_idle;
        end
      end
      PH_SMOOTH: begin
        res.torque_valid = 1'b1;
        if (above && !s2_data.brake && !pend_r) begin
          if (!s2_data.stopped) begin
            phase_nxt = PH_DRIVE;
          end
        end else if (s2_data.stopped) begin
          if (pend_r) begin
            dir_nxt  = s2_data.req;
            pend_nxt = 1'b0;
          end
          phase_nxt      = PH_IDLE;
          res.stop_motor = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    unique case (phase_nxt)
      PH_DRIVE:  res.ctrl_state = ST_DRIVE;
      PH_SMOOTH: res.ctrl_state = ST_SMOOTH;
      default:   res.ctrl_state = ST_IDLE;
    endcase
    res.direction = dir_nxt;
  end

  assign out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      dir_r       <= 1'b0;
      pend_r      <= 1'b0;
      ramp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r <= phase_nxt;
        dir_r   <= dir_nxt;
        pend_r  <= pend_nxt;
        ramp_r  <= ramp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: drive direction torque controller
// Random and directed control ticks go through the core under random
// back-pressure. A tick-level predictor works out every result item, which
// is compared field by field in arrival order. The registers are rewritten
// between phases while the core sits empty.
// ---------------------------------------------------------------------------
module tb;
  import ddtc_pkg::*;

  localparam int unsigned PIPE_DEPTH     = 8;    // four-stage pipe plus margin
  localparam int unsigned TAIL_CYCLES    = 16;
  localparam int unsigned LONG_HOLD      = 300;  // receiver hold-off, cycles
  // idle cycles without any handshake: long hold-off plus the longest gap,
  // register writes and the drain pause, taken several times over
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam int unsigned TQ_KNEE_SHARE  = 80;   // percent of full scale at the knee
  localparam int unsigned TQ_TOP_SHARE   = 20;
  localparam logic [14:0] MASK15         = 15'h7FFF;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_addr  = CFG_MAX_TORQUE;
  logic [14:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  drive_direction_torque_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // Predictor: its own copy of registers and controller state
  // -------------------------------------------------------------------------
  cfg_t        reg_copy;
  logic [1:0]  pr_state = ST_IDLE;
  logic        pr_dir   = 1'b0;
  logic        pr_pend  = 1'b0;
  int unsigned pr_vlim  = 0;

  in_t  pending_ticks[$];     // items waiting for the driver
  out_t expected_results[$];  // predicted result items, oldest first

  // run statistics
  int unsigned n_ticks, n_results, n_errors, n_settings;
  int unsigned n_starts, n_stops, n_reversals, n_torque;

  // global switch for stretches without idling on either side
  logic no_gaps = 1'b0;
  logic hold_req = 1'b0;

  function automatic int unsigned mode_ceiling(logic [1:0] mode);
    int unsigned lim;
    case (mode)
      MODE_ECO:    lim = reg_copy.eco_voltage_limit;
      MODE_NORMAL: lim = reg_copy.normal_voltage_limit;
      default:     lim = reg_copy.sport_voltage_limit;  // sport, and code three
    endcase
    return lim;
  endfunction

  function automatic out_t predict_tick(in_t it);
    out_t        r;
    logic        stopped, above, req;
    logic        old_dir;
    int unsigned tpct, iq, target, d, mag, base;
    r       = '0;
    req     = it.reverse_switch;
    old_dir = pr_dir;
    stopped = (it.shaft_speed == 16'sd0);
    above   = (it.throttle_pct > reg_copy.throttle_start_level);

    // at standstill the forward limit of the mode goes out first
    if (stopped) begin
      r.vlimit_valid = 1'b1;
      r.vlimit_value = 15'(mode_ceiling(it.mode_sel));
    end

    case (pr_state)
      ST_IDLE: begin
        if (pr_dir != req && stopped) begin
          pr_dir = req;
        end
        if (above && !it.brake) begin
          if (pr_dir != req) begin
            pr_pend  = 1'b1;
            pr_state = ST_SMOOTH;
          end else begin
            pr_state = ST_DRIVE;
          end
        end
      end
      ST_DRIVE: begin
        if (it.brake || it.throttle_pct < reg_copy.throttle_start_level || pr_dir != req) begin
          if (pr_dir != req) begin
            pr_pend = 1'b1;
          end
          pr_state = ST_SMOOTH;
        end else begin
          tpct   = (it.throttle_pct > PCT_FULL) ? PCT_FULL : it.throttle_pct;
          base   = pr_dir ? reg_copy.reverse_voltage_limit : mode_ceiling(it.mode_sel);
          target = (base * tpct) / PCT_FULL;
          // ramp towards target, separate step sizes up and down
          if (pr_vlim < target) begin
            d = target - pr_vlim;
            pr_vlim += (reg_copy.ramp_up_step < d) ? reg_copy.ramp_up_step : d;
          end else if (pr_vlim > target) begin
            d = pr_vlim - target;
            pr_vlim -= (reg_copy.ramp_down_step < d) ? reg_copy.ramp_down_step : d;
          end
          pr_vlim &= MASK15;
          r.vlimit_valid = 1'b1;
          r.vlimit_value = 15'(pr_vlim);
          // two-slope curve: knee at 30 percent throttle
          iq = reg_copy.max_torque_current;
          if (tpct < KNEE_PCT) begin
            mag = (tpct * iq * TQ_KNEE_SHARE) / (KNEE_PCT * PCT_FULL);
          end else begin
            mag = (iq * TQ_KNEE_SHARE) / PCT_FULL
                + ((tpct - KNEE_PCT) * iq * TQ_TOP_SHARE) / ((PCT_FULL - KNEE_PCT) * PCT_FULL);
          end
          r.torque_cmd   = pr_dir ? 16'(0 - mag) : 16'(mag);
          r.torque_valid = 1'b1;
          r.start_motor  = it.motor_idle;
        end
      end
      ST_SMOOTH: begin
        r.torque_valid = 1'b1;
        if (above && !it.brake && !pr_pend) begin
          if (!stopped) begin
            pr_state = ST_DRIVE;
          end
        end else if (stopped) begin
          if (pr_pend) begin
            pr_dir  = req;
            pr_pend = 1'b0;
          end
          pr_state  = ST_IDLE;
          r.stop_motor = 1'b1;
        end
      end
      default: begin
        pr_state = ST_IDLE;
      end
    endcase

    r.ctrl_state = pr_state;
    r.direction  = pr_dir;
    if (pr_dir != old_dir) n_reversals++;
    if (r.start_motor) n_starts++;
    if (r.stop_motor) n_stops++;
    if (r.torque_valid) n_torque++;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Idling: mostly short gaps, now and then a long one
  // -------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // -------------------------------------------------------------------------
  // Driver: offers queued items at the falling edge
  // -------------------------------------------------------------------------
  logic        in_taken = 1'b0;
  int unsigned in_gap   = 0;

  always @(negedge clk) begin : tick_driver
    logic nxt_valid;
    if (rst_n && (!in_valid || in_taken)) begin
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_ticks.size() != 0) begin
        in_data  <= pending_ticks.pop_front();
        nxt_valid = 1'b1;
        in_gap    = pick_gap();
      end
      in_valid <= nxt_valid;
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // -------------------------------------------------------------------------
  int unsigned out_gap   = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin : result_sink
    logic nxt_ready;
    if (rst_n) begin
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      nxt_ready = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (out_gap > 0) begin
        out_gap--;
      end else begin
        nxt_ready = 1'b1;
        out_gap   = pick_gap();
      end
      out_ready <= nxt_ready;
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: predicts on input handshakes, checks on output handshakes
  // -------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_tick(in_data));
        n_ticks++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result item with nothing expected, got %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("ctrl_state",   want.ctrl_state,   out_data.ctrl_state);
          check_field("direction",    want.direction,    out_data.direction);
          check_field("torque_valid", want.torque_valid, out_data.torque_valid);
          check_field("torque_cmd",   want.torque_cmd,   out_data.torque_cmd);
          check_field("vlimit_valid", want.vlimit_valid, out_data.vlimit_valid);
          check_field("vlimit_value", want.vlimit_value, out_data.vlimit_value);
          check_field("start_motor",  want.start_motor,  out_data.start_motor);
          check_field("stop_motor",   want.stop_motor,   out_data.stop_motor);
        end
      end
      // watchdog: stretch with no handshake on either channel
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                   $time, quiet_cycles, expected_results.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  function automatic in_t mk_tick(logic [7:0] thr, logic brk, logic rev, logic [1:0] mode,
                                  logic signed [15:0] spd, logic idl);
    in_t it;
    it.throttle_pct   = thr;
    it.brake          = brk;
    it.reverse_switch = rev;
    it.mode_sel       = mode;
    it.shaft_speed    = spd;
    it.motor_idle     = idl;
    return it;
  endfunction

  // one drive from standstill to standstill; now and then broken by
  // a direction flip on the move, a brake dab or an odd mode
  function automatic int unsigned push_episode();
    logic              rev;
    logic [1:0]        mode;
    int unsigned       len, roll;
    logic [7:0]        thr;
    logic signed [15:0] spd;
    logic              brk;
    rev  = 1'($urandom_range(0, 1));
    mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
    len  = $urandom_range(6, 30);
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)       thr = 8'($urandom_range(0, 12));
      else if (roll < 18) thr = 8'($urandom_range(101, 255));
      else                thr = 8'($urandom_range(15, 100));
      brk = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 14) == 0) mode = 2'($urandom_range(0, 3));
      if (i < 2) begin
        spd = '0;
      end else if (i + 3 >= len) begin
        // wind down to a stop
        spd = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'sd0;
        thr = 8'($urandom_range(0, 5));
        brk = 1'($urandom_range(0, 1));
      end else begin
        spd = ($urandom_range(0, 19) == 0) ? 16'sd0 : 16'($urandom);
      end
      pending_ticks.push_back(mk_tick(thr, brk, rev ^ ($urandom_range(0, 24) == 0), mode, spd,
                                      (i < 3) ? 1'b1 : ($urandom_range(0, 9) == 0)));
    end
    return len;
  endfunction

  function automatic int unsigned push_noise();
    int unsigned n;
    n = $urandom_range(1, 5);
    for (int unsigned i = 0; i < n; i++) begin
      pending_ticks.push_back(mk_tick(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                      ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom),
                                      1'($urandom_range(0, 1))));
    end
    return n;
  endfunction

  task automatic queue_random(int unsigned n_items);
    int unsigned pushed;
    pushed = 0;
    while (pushed < n_items) begin
      if ($urandom_range(0, 4) != 0) pushed += push_episode();
      else pushed += push_noise();
    end
  endtask

  // sender pause: waits until nothing is in flight, then for the pipe depth margin
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  task automatic load_registers(int unsigned vals[8]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= cfg_idx_t'(i);
      cfg_wdata <= 15'(vals[i]);
      case (cfg_idx_t'(i))
        CFG_MAX_TORQUE:   reg_copy.max_torque_current    = 15'(vals[i]);
        CFG_ECO_VLIM:     reg_copy.eco_voltage_limit     = 15'(vals[i]);
        CFG_NORMAL_VLIM:  reg_copy.normal_voltage_limit  = 15'(vals[i]);
        CFG_SPORT_VLIM:   reg_copy.sport_voltage_limit   = 15'(vals[i]);
        CFG_REVERSE_VLIM: reg_copy.reverse_voltage_limit = 15'(vals[i]);
        CFG_START_LEVEL:  reg_copy.throttle_start_level  = 7'(vals[i]);
        CFG_RAMP_UP:      reg_copy.ramp_up_step          = 10'(vals[i]);
        default:          reg_copy.ramp_down_step        = 10'(vals[i]);
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    int unsigned regs[8];
    reg_copy = '{max_torque_current: 15'd10000, eco_voltage_limit: 15'd16700,
                 normal_voltage_limit: 15'd22200, sport_voltage_limit: 15'd24000,
                 reverse_voltage_limit: 15'd12000, throttle_start_level: 7'd10,
                 ramp_up_step: 10'd10, ramp_down_step: 10'd1};
    n_settings = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed walk through the machine with reset registers
    pending_ticks.push_back(mk_tick(8'd0,   0, 0, MODE_ECO,    16'sd0,     0)); // idle at rest
    pending_ticks.push_back(mk_tick(8'd0,   0, 1, MODE_NORMAL, 16'sd0,     0)); // reverse at rest
    pending_ticks.push_back(mk_tick(8'd255, 0, 1, MODE_SPARE,  16'sd0,     1)); // mode three
    pending_ticks.push_back(mk_tick(8'd255, 0, 1, MODE_SPARE,  16'sh8000,  1)); // clamp, start
    pending_ticks.push_back(mk_tick(8'd29,  0, 1, MODE_SPORT,  16'sd100,   0)); // below knee
    pending_ticks.push_back(mk_tick(8'd30,  0, 1, MODE_ECO,    16'sd100,   0)); // at knee
    pending_ticks.push_back(mk_tick(8'd100, 0, 1, MODE_NORMAL, 16'sd200,   0));
    pending_ticks.push_back(mk_tick(8'd100, 0, 0, MODE_NORMAL, 16'sd200,   0)); // flip on the move
    pending_ticks.push_back(mk_tick(8'd80,  0, 0, MODE_NORMAL, -16'sd50,   0)); // pending holds
    pending_ticks.push_back(mk_tick(8'd0,   0, 0, MODE_NORMAL, 16'sd0,     0)); // reversal at rest
    pending_ticks.push_back(mk_tick(8'd10,  0, 0, MODE_ECO,    16'sd0,     0)); // at start level
    pending_ticks.push_back(mk_tick(8'd11,  0, 0, MODE_ECO,    16'sd0,     1));
    pending_ticks.push_back(mk_tick(8'd10,  0, 0, MODE_ECO,    16'sd0,     1)); // level, stays
    pending_ticks.push_back(mk_tick(8'd9,   0, 0, MODE_ECO,    16'sd5,     0)); // below level
    pending_ticks.push_back(mk_tick(8'd50,  0, 0, MODE_ECO,    16'sd5,     0)); // resume
    pending_ticks.push_back(mk_tick(8'd50,  1, 0, MODE_ECO,    16'sd5,     0)); // brake
    pending_ticks.push_back(mk_tick(8'd50,  1, 0, MODE_ECO,    16'sd5,     0));
    pending_ticks.push_back(mk_tick(8'd50,  1, 0, MODE_ECO,    16'sd0,     0)); // stop pulse
    pending_ticks.push_back(mk_tick(8'd50,  1, 0, MODE_ECO,    16'sd0,     0)); // idle, braked
    pending_ticks.push_back(mk_tick(8'd50,  0, 1, MODE_ECO,    16'sd7,     0)); // reverse moving
    pending_ticks.push_back(mk_tick(8'd50,  0, 1, MODE_ECO,    16'sd0,     0));
    pending_ticks.push_back(mk_tick(8'd60,  0, 0, MODE_NORMAL, 16'sd0,     0)); // fwd at rest
    pending_ticks.push_back(mk_tick(8'd100, 0, 0, MODE_NORMAL, 16'sd0,     1)); // two limit writes
    pending_ticks.push_back(mk_tick(8'd60,  0, 0, MODE_ECO,    16'sd32767, 1));
    pending_ticks.push_back(mk_tick(8'd0,   1, 0, MODE_ECO,    16'sd0,     0));
    queue_random(350);
    wait_drained();

    // top of every range but the start level, which is zero; no idling anywhere and one long output hold-off
    regs = '{32767, 32767, 32767, 32767, 32767, 0, 1000, 1000};
    load_registers(regs);
    no_gaps = 1'b1;
    queue_random(300);
    hold_req = 1'b1;
    wait_drained();
    no_gaps = 1'b0;

    // bottom of every range but the start level, which is at 100
    regs = '{0, 0, 0, 0, 0, 100, 1, 1};
    load_registers(regs);
    queue_random(150);
    wait_drained();

    // random settings; one frozen ramp direction in each of the first two
    for (int p = 0; p < 3; p++) begin
      regs[CFG_MAX_TORQUE]   = $urandom_range(0, 32767);
      regs[CFG_ECO_VLIM]     = $urandom_range(0, 32767);
      regs[CFG_NORMAL_VLIM]  = $urandom_range(0, 32767);
      regs[CFG_SPORT_VLIM]   = $urandom_range(0, 32767);
      regs[CFG_REVERSE_VLIM] = $urandom_range(0, 32767);
      regs[CFG_START_LEVEL]  = $urandom_range(0, 100);
      regs[CFG_RAMP_UP]      = (p == 0) ? 0 : $urandom_range(1, 1000);
      regs[CFG_RAMP_DOWN]    = (p == 1) ? 0 : $urandom_range(1, 1000);
      load_registers(regs);
      queue_random(220);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run: %0d ticks over %0d register settings, %0d results checked, %0d errors",
             n_ticks, n_settings, n_results, n_errors);
    $display("Seen: %0d torque commands, %0d start and %0d stop pulses, %0d reversals",
             n_torque, n_starts, n_stops, n_reversals);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
